@@ rtl/dbp_pkg.sv @@
// Shared constants and types for the depth back-projection unit.
// Used by dbp_cell and depth_to_point_backprojection_unit; depends on nothing.
package dbp_pkg;

  localparam int DEPTH_BITS = 16;
  localparam int FRAC_BITS  = 8;
  localparam int CFG_W      = 20;
  localparam int SIZE_W     = 13;
  localparam int POS_W      = 14;
  localparam int MAG_W      = POS_W + FRAC_BITS;
  localparam int PROD_W     = MAG_W + DEPTH_BITS;
  localparam int NUM_W      = PROD_W;
  localparam int REM_W      = CFG_W;
  localparam int XY_W       = 37;
  localparam int MAX_DIM    = 4096;

  localparam logic [2:0] REG_FOCAL_X  = 3'd0;
  localparam logic [2:0] REG_FOCAL_Y  = 3'd1;
  localparam logic [2:0] REG_CENTER_X = 3'd2;
  localparam logic [2:0] REG_CENTER_Y = 3'd3;
  localparam logic [2:0] REG_WIDTH    = 3'd4;
  localparam logic [2:0] REG_HEIGHT   = 3'd5;

  // One division lane: partial remainder, and a word that shifts out dividend
  // bits at the top while quotient bits enter at the bottom.
  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [NUM_W-1:0] num;
  } dbp_lane_t;

  typedef struct packed {
    logic                  valid;
    dbp_lane_t             lx;
    dbp_lane_t             ly;
    logic [DEPTH_BITS-1:0] z;
    logic                  eor;
    logic                  eof;
    logic                  negx;
    logic                  negy;
  } dbp_cell_t;

endpackage

@@ rtl/dbp_cell.sv @@
// One restoring-division cell: produces one quotient bit for the x and y lanes.
// Depends on dbp_pkg.
module dbp_cell import dbp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic [CFG_W-1:0] fx,
  input  logic [CFG_W-1:0] fy,
  input  dbp_cell_t        d_in,
  output dbp_cell_t        d_out
);

  function automatic dbp_lane_t div_step(dbp_lane_t l, logic [CFG_W-1:0] f);
    logic [REM_W:0] t;
    logic [REM_W:0] df;
    dbp_lane_t      r;
    t = {l.rem, l.num[NUM_W-1]};
    df = {1'b0, f};
    r.num = {l.num[NUM_W-2:0], 1'b0};
    if (t >= df) begin
      r.rem = REM_W'(t - df);
      r.num[0] = 1'b1;
    end else begin
      r.rem = t[REM_W-1:0];
    end
    return r;
  endfunction

  dbp_cell_t data_r, data_nxt;
  logic      valid_r;

  always_comb begin
    data_nxt = d_in;
    data_nxt.lx = div_step(d_in.lx, fx);
    data_nxt.ly = div_step(d_in.ly, fy);
  end

  always_ff @(posedge clk) begin
    if (adv) data_r <= data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= d_in.valid;
    end
  end

  always_comb begin
    d_out = data_r;
    d_out.valid = valid_r;
  end

endmodule

@@ rtl/depth_to_point_backprojection_unit.sv @@
// Pinhole back-projection of a raster depth stream to x, y, z points.
// Depends on dbp_pkg and dbp_cell.
//
// Each accepted depth sample yields one point: x = (col - cx) * z / fx and
// y = (row - cy) * z / fy with 8 fraction bits, truncated toward zero and
// saturated to 37 bits, plus z, end of row (tlast) and end of frame (tuser).
// The pipeline registers position and offset, then the multiply, then passes
// through a chain of 38 divider cells that each produce one quotient bit,
// and ends in the output register. A new sample is taken every cycle while
// the output is not stalled.
module depth_to_point_backprojection_unit import dbp_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_DIM,
  parameter int MAX_HEIGHT = MAX_DIM
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [15:0]      in_tdata,   // [15:0] depth_sample
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [95:0]      out_tdata,  // [36:0] point_x, [73:37] point_y, [89:74] point_z
  output logic             out_tlast,  // end_of_row
  output logic             out_tuser,  // end_of_frame
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam logic [POS_W:0] MAXW = (POS_W + 1)'(MAX_WIDTH);
  localparam logic [POS_W:0] MAXH = (POS_W + 1)'(MAX_HEIGHT);
  localparam logic [CFG_W-1:0] ONE_Q = CFG_W'(1 << FRAC_BITS);
  localparam logic [XY_W-1:0] POS_MAX = {1'b0, {(XY_W - 1){1'b1}}};
  localparam logic [NUM_W-1:0] NEG_MAG = NUM_W'(1) << (XY_W - 1);

  logic [CFG_W-1:0]  focal_x_r, focal_y_r, center_x_r, center_y_r;
  logic [SIZE_W-1:0] width_r, height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_x_r  <= ONE_Q;
      focal_y_r  <= ONE_Q;
      center_x_r <= '0;
      center_y_r <= '0;
      width_r    <= SIZE_W'(640);
      height_r   <= SIZE_W'(480);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FOCAL_X:  focal_x_r  <= cfg_wdata;
        REG_FOCAL_Y:  focal_y_r  <= cfg_wdata;
        REG_CENTER_X: center_x_r <= cfg_wdata;
        REG_CENTER_Y: center_y_r <= cfg_wdata;
        REG_WIDTH:    width_r    <= cfg_wdata[SIZE_W-1:0];
        REG_HEIGHT:   height_r   <= cfg_wdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  logic [CFG_W-1:0] fx, fy;
  assign fx = (focal_x_r < ONE_Q) ? ONE_Q : focal_x_r;
  assign fy = (focal_y_r < ONE_Q) ? ONE_Q : focal_y_r;

  logic adv, in_acc;
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;
  assign in_acc    = in_tvalid && adv;

  // Position counters and frame limits.
  logic [CW-1:0]  col_r, col_nxt;
  logic [RW-1:0]  row_r, row_nxt;
  logic [POS_W:0] w_eff, h_eff, w_ext, h_ext;
  logic           eor, eof;

  always_comb begin
    w_ext = (POS_W + 1)'(width_r);
    h_ext = (POS_W + 1)'(height_r);
    w_eff = (w_ext == '0) ? (POS_W + 1)'(1) : ((w_ext > MAXW) ? MAXW : w_ext);
    h_eff = (h_ext == '0) ? (POS_W + 1)'(1) : ((h_ext > MAXH) ? MAXH : h_ext);
    eor = (POS_W + 1)'(col_r) >= (w_eff - 1'b1);
    eof = eor && ((POS_W + 1)'(row_r) >= (h_eff - 1'b1));
    col_nxt = eor ? '0 : col_r + 1'b1;
    row_nxt = eof ? '0 : (eor ? row_r + 1'b1 : row_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Stage 0: offset from the principal point, as sign and magnitude.
  logic [MAG_W-1:0]      px, py, cx, cy;
  logic                  s0_valid_r;
  logic [MAG_W-1:0]      s0_magx_r, s0_magy_r;
  logic                  s0_negx_r, s0_negy_r, s0_eor_r, s0_eof_r;
  logic [DEPTH_BITS-1:0] s0_z_r;

  assign px = {POS_W'(col_r), {FRAC_BITS{1'b0}}};
  assign py = {POS_W'(row_r), {FRAC_BITS{1'b0}}};
  assign cx = MAG_W'(center_x_r);
  assign cy = MAG_W'(center_y_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_negx_r <= px < cx;
      s0_negy_r <= py < cy;
      s0_magx_r <= (px < cx) ? cx - px : px - cx;
      s0_magy_r <= (py < cy) ? cy - py : py - cy;
      s0_z_r    <= in_tdata[DEPTH_BITS-1:0];
      s0_eor_r  <= eor;
      s0_eof_r  <= eof;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s0_valid_r <= 1'b0;
    else if (adv) s0_valid_r <= in_acc;
  end

  // Stage 1: offset times depth, loaded into the divider lanes.
  logic [PROD_W-1:0] prodx, prody;
  dbp_cell_t         s1_r, s1_nxt;
  logic              s1_valid_r;

  assign prodx = PROD_W'(s0_magx_r) * PROD_W'(s0_z_r);
  assign prody = PROD_W'(s0_magy_r) * PROD_W'(s0_z_r);

  always_comb begin
    s1_nxt.valid  = s0_valid_r;
    s1_nxt.lx.rem = REM_W'(prodx[PROD_W-1 -: FRAC_BITS]);
    s1_nxt.lx.num = {prodx[PROD_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
    s1_nxt.ly.rem = REM_W'(prody[PROD_W-1 -: FRAC_BITS]);
    s1_nxt.ly.num = {prody[PROD_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
    s1_nxt.z      = s0_z_r;
    s1_nxt.eor    = s0_eor_r;
    s1_nxt.eof    = s0_eof_r;
    s1_nxt.negx   = s0_negx_r;
    s1_nxt.negy   = s0_negy_r;
  end

  always_ff @(posedge clk) begin
    if (adv) s1_r <= s1_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s1_valid_r <= 1'b0;
    else if (adv) s1_valid_r <= s0_valid_r;
  end

  dbp_cell_t chain [NUM_W+1];

  always_comb begin
    chain[0] = s1_r;
    chain[0].valid = s1_valid_r;
  end

  for (genvar i = 0; i < NUM_W; i++) begin : g_cell
    dbp_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .fx    (fx),
      .fy    (fy),
      .d_in  (chain[i]),
      .d_out (chain[i+1])
    );
  end

  // Output register with saturation to the signed coordinate range.
  function automatic logic [XY_W-1:0] sat_xy(logic [NUM_W-1:0] q, logic neg);
    logic [NUM_W-1:0] m;
    if (neg) begin
      m = (q > NEG_MAG) ? NEG_MAG : q;
      return XY_W'(-m);
    end
    return (q > NUM_W'(POS_MAX)) ? POS_MAX : q[XY_W-1:0];
  endfunction

  dbp_cell_t        tail;
  logic             out_valid_r;
  logic [XY_W-1:0]  ox_r, oy_r;
  logic [DEPTH_BITS-1:0] oz_r;
  logic             oeor_r, oeof_r;

  assign tail = chain[NUM_W];

  always_ff @(posedge clk) begin
    if (adv) begin
      ox_r   <= sat_xy(tail.lx.num, tail.negx);
      oy_r   <= sat_xy(tail.ly.num, tail.negy);
      oz_r   <= tail.z;
      oeor_r <= tail.eor;
      oeof_r <= tail.eof;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (adv) out_valid_r <= tail.valid;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, oz_r, oy_r, ox_r};
  assign out_tlast  = oeor_r;
  assign out_tuser  = oeof_r;

  // The end of a frame is always also the end of a row.
  a_eof_eor: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!out_tuser || out_tlast))
    else $error("end of frame without end of row");

  // The column counter stays below the widest frame.
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    (POS_W + 1)'(col_r) < MAXW)
    else $error("column counter out of range");

  // A stalled output holds the whole pipeline, counters included.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> ($stable(col_r) && $stable(row_r)))
    else $error("counters moved during stall");

endmodule
